// File: design/dpff_pkg.sv
// Shared types and constants for the demand paging fault fill block.
package dpff_pkg;

   localparam int ADDR_W   = 32;
   localparam int TFRAME_W = 4;
   localparam int PFRAME_W = 20;
   localparam int ENTRY_W  = 32;
   localparam int CSR_W    = 4;

   localparam int ENTRIES     = 1024;
   localparam int IDX_W       = 10;
   localparam int DIR_SHIFT   = 22;
   localparam int TABLE_SHIFT = 12;

   localparam logic [TABLE_SHIFT-1:0] FLAGS_DIR_NEW    = 12'h003;
   localparam logic [ENTRY_W-1:0]     FLAGS_TABLE_FILL = 32'h0000_0006;
   localparam logic [TABLE_SHIFT-1:0] FLAGS_PAGE_NEW   = 12'h007;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIR_MOD,
      ST_DIR_RD,
      ST_DIR_CHK,
      ST_TAB_MOD,
      ST_FILL,
      ST_WALK_MOD,
      ST_PAGE_RD,
      ST_PAGE_CHK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SRC_DIR,
      SRC_TAB,
      SRC_WALK
   } rem_src_type;

   typedef struct packed {
      logic        load_req;
      logic        rem_start;
      logic        rem_cap;
      rem_src_type rem_src;
      logic        cnt_clr;
      logic        cnt_inc;
      logic        clr_write;
      logic        dir_write;
      logic        fill_write;
      logic        page_write;
      logic        rd_dir;
      logic        rd_page;
      logic        latch_dir;
      logic        latch_page;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic present;
      logic created;
      logic rem_done;
      logic clear_last;
      logic fill_last;
   } status_type;

endpackage

// File: design/dpff_ifs.sv
// Valid/ready channel interfaces for the fault request and the fill response.
interface dpff_req_if;
   logic                          valid;
   logic                          ready;
   logic [dpff_pkg::ADDR_W-1:0]   fault_address;
   logic [dpff_pkg::TFRAME_W-1:0] table_frame;
   logic [dpff_pkg::PFRAME_W-1:0] page_frame;

   modport source (output valid, output fault_address, output table_frame,
                   output page_frame, input ready);
   modport sink (input valid, input fault_address, input table_frame,
                 input page_frame, output ready);
endinterface

interface dpff_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         table_created;
   logic                         page_mapped;
   logic [dpff_pkg::ENTRY_W-1:0] directory_entry;
   logic [dpff_pkg::ENTRY_W-1:0] page_entry;

   modport source (output valid, output table_created, output page_mapped,
                   output directory_entry, output page_entry, input ready);
   modport sink (input valid, input table_created, input page_mapped,
                 input directory_entry, input page_entry, output ready);
endinterface

// File: design/demand_paging_fault_fill.sv
// Top level of the demand paging fault fill block.
// After reset the block clears its frame memory of MEM_FRAMES * 1024 words, one word
// per cycle, and takes no fault word until that pass is done; writes to the directory
// frame register are taken at any time. Each fault word is then walked one at a time.
// A walk that finds the directory entry present makes two passes through the remainder
// unit that reduces frame numbers to the memory size, plus the memory reads and checks,
// then puts out its response word and is ready for the next fault word as soon as that
// response word appears. A walk that allocates a page table also fills its 1024
// entries through the one memory write port and adds one more remainder pass and a
// reread of the directory entry. The next fault word is accepted while the previous
// response word still waits to be taken, but a walk holds in its last cycle until that
// response word is gone.
module demand_paging_fault_fill #(
   parameter int MEM_FRAMES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   dpff_req_if.sink                   req_bus,
   dpff_rsp_if.source                 rsp_bus,
   input  logic                       csr_write_en,
   input  logic [dpff_pkg::CSR_W-1:0] csr_write_data
);

   dpff_pkg::cmd_type    cmd;
   dpff_pkg::status_type status;

   dpff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpff_datapath #(.MEM_FRAMES(MEM_FRAMES)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .status          (status),
      .fault_address   (req_bus.fault_address),
      .table_frame     (req_bus.table_frame),
      .page_frame      (req_bus.page_frame),
      .table_created   (rsp_bus.table_created),
      .page_mapped     (rsp_bus.page_mapped),
      .directory_entry (rsp_bus.directory_entry),
      .page_entry      (rsp_bus.page_entry)
   );

   // At most one source drives the memory write port in any cycle.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_write, cmd.dir_write, cmd.fill_write, cmd.page_write}))
      else $error("more than one memory write source active");

   // A new response word never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response register loaded while occupied");

   // A single fault allocates at most one page table.
   a_single_alloc: assert property (@(posedge clock) disable iff (reset)
      cmd.dir_write |-> !status.created)
      else $error("second table allocation within one fault");

   // No fault word is taken while the memory clear pass or a table fill is running.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> !cmd.clr_write && !cmd.fill_write)
      else $error("fault word accepted while memory busy");

endmodule

// File: design/dpff_rem.sv
// Remainder unit that reduces a frame number modulo the frame count by reciprocal multiplication.
module dpff_rem #(
   parameter int MEM_FRAMES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [dpff_pkg::PFRAME_W-1:0]       value,
   output logic                                done,
   output logic [$clog2(MEM_FRAMES)-1:0]       rem
);

   localparam int     FW    = $clog2(MEM_FRAMES);
   localparam int     VW    = dpff_pkg::PFRAME_W;
   localparam int     RW    = VW + 1;
   localparam int     PW    = VW + RW;
   localparam int     SHIFT = VW + FW;
   localparam int     QW    = PW - SHIFT;
   // The reciprocal is rounded up; with this shift the quotient is exact for every value.
   localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(MEM_FRAMES) - 1) /
                              longint'(MEM_FRAMES);
   localparam logic [RW-1:0] RECIP_VEC = RW'(RECIP);
   localparam logic [FW-1:0] DIV_LO    = FW'(MEM_FRAMES);

   logic          stage1_ff, stage1_in;
   logic          stage2_ff, stage2_in;
   logic          done_ff, done_in;
   logic [VW-1:0] val_ff, val_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [FW-1:0] rem_ff, rem_in;
   logic [PW-1:0] product;
   logic [FW-1:0] back_lo;

   // The remainder is below 2**FW, so only the low bits of value - quotient * count matter.
   always_comb begin
      product   = {{RW{1'b0}}, val_ff} * {{VW{1'b0}}, RECIP_VEC};
      back_lo   = quo_ff[FW-1:0] * DIV_LO;
      stage1_in = start;
      stage2_in = stage1_ff;
      done_in   = stage2_ff;
      val_in    = start ? value : val_ff;
      quo_in    = stage1_ff ? product[PW-1:SHIFT] : quo_ff;
      rem_in    = stage2_ff ? val_ff[FW-1:0] - back_lo : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= stage1_in;
         stage2_ff <= stage2_in;
         done_ff   <= done_in;
      end
      val_ff <= val_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// File: design/dpff_datapath.sv
// Datapath: frame memory, sweep counter, frame reduction and result registers.
module dpff_datapath #(
   parameter int MEM_FRAMES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [dpff_pkg::CSR_W-1:0]          csr_write_data,
   input  dpff_pkg::cmd_type                   cmd,
   output dpff_pkg::status_type                status,
   input  logic [dpff_pkg::ADDR_W-1:0]         fault_address,
   input  logic [dpff_pkg::TFRAME_W-1:0]       table_frame,
   input  logic [dpff_pkg::PFRAME_W-1:0]       page_frame,
   output logic                                table_created,
   output logic                                page_mapped,
   output logic [dpff_pkg::ENTRY_W-1:0]        directory_entry,
   output logic [dpff_pkg::ENTRY_W-1:0]        page_entry
);

   localparam int FW    = $clog2(MEM_FRAMES);
   localparam int AW    = FW + dpff_pkg::IDX_W;
   localparam int DEPTH = MEM_FRAMES * dpff_pkg::ENTRIES;

   logic [dpff_pkg::ENTRY_W-1:0]  mem_ff [DEPTH];
   logic [dpff_pkg::ENTRY_W-1:0]  rd_ff;

   logic [dpff_pkg::CSR_W-1:0]    dir_frame_ff, dir_frame_in;
   logic [dpff_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [dpff_pkg::TFRAME_W-1:0] tframe_ff, tframe_in;
   logic [dpff_pkg::PFRAME_W-1:0] pframe_ff, pframe_in;
   logic [FW-1:0]                 dir_mod_ff, dir_mod_in;
   logic [FW-1:0]                 tab_mod_ff, tab_mod_in;
   logic [FW-1:0]                 walk_mod_ff, walk_mod_in;
   logic [AW-1:0]                 cnt_ff, cnt_in;
   logic                          created_ff, created_in;
   logic                          mapped_ff, mapped_in;
   logic [dpff_pkg::ENTRY_W-1:0]  dir_entry_ff, dir_entry_in;
   logic [dpff_pkg::ENTRY_W-1:0]  page_entry_ff, page_entry_in;
   logic                          out_created_ff, out_created_in;
   logic                          out_mapped_ff, out_mapped_in;
   logic [dpff_pkg::ENTRY_W-1:0]  out_dir_ff, out_dir_in;
   logic [dpff_pkg::ENTRY_W-1:0]  out_page_ff, out_page_in;

   logic [AW-1:0]                 dir_at, page_at, wr_addr, rd_addr;
   logic [dpff_pkg::ENTRY_W-1:0]  wr_data, page_value;
   logic                          wr_en, rd_en;
   logic [dpff_pkg::PFRAME_W-1:0] rem_value;
   logic                          rem_done;
   logic [FW-1:0]                 rem_out;

   assign dir_at  = {dir_mod_ff, addr_ff[dpff_pkg::DIR_SHIFT +: dpff_pkg::IDX_W]};
   assign page_at = {walk_mod_ff, addr_ff[dpff_pkg::TABLE_SHIFT +: dpff_pkg::IDX_W]};
   assign page_value = {pframe_ff, dpff_pkg::FLAGS_PAGE_NEW};

   always_comb begin
      case (cmd.rem_src)
         dpff_pkg::SRC_DIR:  rem_value = dpff_pkg::PFRAME_W'(dir_frame_ff);
         dpff_pkg::SRC_TAB:  rem_value = dpff_pkg::PFRAME_W'(tframe_ff);
         dpff_pkg::SRC_WALK: rem_value = rd_ff[dpff_pkg::ENTRY_W-1:dpff_pkg::TABLE_SHIFT];
         default:            rem_value = '0;
      endcase
   end

   dpff_rem #(.MEM_FRAMES(MEM_FRAMES)) u_rem (
      .clock (clock),
      .reset (reset),
      .start (cmd.rem_start),
      .value (rem_value),
      .done  (rem_done),
      .rem   (rem_out)
   );

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = page_at;
      wr_data = page_value;
      if (cmd.clr_write) begin
         wr_addr = cnt_ff;
         wr_data = '0;
      end else if (cmd.dir_write) begin
         wr_addr = dir_at;
         wr_data = {16'h0000, tframe_ff, dpff_pkg::FLAGS_DIR_NEW};
      end else if (cmd.fill_write) begin
         wr_addr = {tab_mod_ff, cnt_ff[dpff_pkg::IDX_W-1:0]};
         wr_data = dpff_pkg::FLAGS_TABLE_FILL;
      end else if (!cmd.page_write) begin
         wr_en = 1'b0;
      end
      rd_en   = cmd.rd_dir | cmd.rd_page;
      rd_addr = cmd.rd_dir ? dir_at : page_at;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      dir_frame_in   = csr_write_en ? csr_write_data : dir_frame_ff;
      addr_in        = cmd.load_req ? fault_address : addr_ff;
      tframe_in      = cmd.load_req ? table_frame : tframe_ff;
      pframe_in      = cmd.load_req ? page_frame : pframe_ff;
      dir_mod_in     = dir_mod_ff;
      tab_mod_in     = tab_mod_ff;
      walk_mod_in    = walk_mod_ff;
      cnt_in         = cnt_ff;
      created_in     = created_ff;
      mapped_in      = mapped_ff;
      dir_entry_in   = dir_entry_ff;
      page_entry_in  = page_entry_ff;
      out_created_in = out_created_ff;
      out_mapped_in  = out_mapped_ff;
      out_dir_in     = out_dir_ff;
      out_page_in    = out_page_ff;

      if (cmd.rem_cap) begin
         case (cmd.rem_src)
            dpff_pkg::SRC_DIR:  dir_mod_in  = rem_out;
            dpff_pkg::SRC_TAB:  tab_mod_in  = rem_out;
            dpff_pkg::SRC_WALK: walk_mod_in = rem_out;
            default:            dir_mod_in  = dir_mod_ff;
         endcase
      end
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.load_req) begin
         created_in = 1'b0;
         mapped_in  = 1'b0;
      end
      if (cmd.dir_write) begin
         created_in = 1'b1;
      end
      if (cmd.latch_dir) begin
         dir_entry_in = rd_ff;
      end
      if (cmd.latch_page) begin
         page_entry_in = rd_ff;
      end
      if (cmd.page_write) begin
         mapped_in     = 1'b1;
         page_entry_in = page_value;
         // The page table in use may be the directory itself.
         if (page_at == dir_at) begin
            dir_entry_in = page_value;
         end
      end
      if (cmd.out_load) begin
         out_created_in = created_ff;
         out_mapped_in  = mapped_ff;
         out_dir_in     = dir_entry_ff;
         out_page_in    = page_entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_frame_ff <= '0;
         cnt_ff       <= '0;
         created_ff   <= 1'b0;
      end else begin
         dir_frame_ff <= dir_frame_in;
         cnt_ff       <= cnt_in;
         created_ff   <= created_in;
      end
      addr_ff        <= addr_in;
      tframe_ff      <= tframe_in;
      pframe_ff      <= pframe_in;
      dir_mod_ff     <= dir_mod_in;
      tab_mod_ff     <= tab_mod_in;
      walk_mod_ff    <= walk_mod_in;
      mapped_ff      <= mapped_in;
      dir_entry_ff   <= dir_entry_in;
      page_entry_ff  <= page_entry_in;
      out_created_ff <= out_created_in;
      out_mapped_ff  <= out_mapped_in;
      out_dir_ff     <= out_dir_in;
      out_page_ff    <= out_page_in;
   end

   assign status.present    = rd_ff[0];
   assign status.created    = created_ff;
   assign status.rem_done   = rem_done;
   assign status.clear_last = (cnt_ff == AW'(DEPTH - 1));
   assign status.fill_last  = (cnt_ff[dpff_pkg::IDX_W-1:0] ==
                               dpff_pkg::IDX_W'(dpff_pkg::ENTRIES - 1));

   assign table_created   = out_created_ff;
   assign page_mapped     = out_mapped_ff;
   assign directory_entry = out_dir_ff;
   assign page_entry      = out_page_ff;

endmodule

// File: design/dpff_ctrl.sv
// Controller state machine that sequences the clear pass and each table walk.
module dpff_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dpff_pkg::status_type status,
   output dpff_pkg::cmd_type    cmd
);

   dpff_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dpff_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = dpff_pkg::ST_IDLE;
         end
         dpff_pkg::ST_IDLE: begin
            if (req_valid) state_in = dpff_pkg::ST_DIR_MOD;
         end
         dpff_pkg::ST_DIR_MOD: begin
            if (status.rem_done) state_in = dpff_pkg::ST_DIR_RD;
         end
         dpff_pkg::ST_DIR_RD: state_in = dpff_pkg::ST_DIR_CHK;
         dpff_pkg::ST_DIR_CHK: begin
            if (!status.present && !status.created) begin
               state_in = dpff_pkg::ST_TAB_MOD;
            end else begin
               state_in = dpff_pkg::ST_WALK_MOD;
            end
         end
         dpff_pkg::ST_TAB_MOD: begin
            if (status.rem_done) state_in = dpff_pkg::ST_FILL;
         end
         dpff_pkg::ST_FILL: begin
            // Reread the directory entry; the fill may have landed on it.
            if (status.fill_last) state_in = dpff_pkg::ST_DIR_RD;
         end
         dpff_pkg::ST_WALK_MOD: begin
            if (status.rem_done) state_in = dpff_pkg::ST_PAGE_RD;
         end
         dpff_pkg::ST_PAGE_RD: state_in = dpff_pkg::ST_PAGE_CHK;
         dpff_pkg::ST_PAGE_CHK: state_in = dpff_pkg::ST_DONE;
         dpff_pkg::ST_DONE: begin
            if (out_free) state_in = dpff_pkg::ST_IDLE;
         end
         default: state_in = dpff_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         dpff_pkg::ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            cmd.cnt_inc   = 1'b1;
            cmd.cnt_clr   = status.clear_last;
         end
         dpff_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_req  = req_valid;
            cmd.rem_start = req_valid;
            cmd.rem_src   = dpff_pkg::SRC_DIR;
         end
         dpff_pkg::ST_DIR_MOD: begin
            cmd.rem_src = dpff_pkg::SRC_DIR;
            cmd.rem_cap = status.rem_done;
         end
         dpff_pkg::ST_DIR_RD: begin
            cmd.rd_dir = 1'b1;
         end
         dpff_pkg::ST_DIR_CHK: begin
            cmd.rem_start = 1'b1;
            if (!status.present && !status.created) begin
               cmd.dir_write = 1'b1;
               cmd.cnt_clr   = 1'b1;
               cmd.rem_src   = dpff_pkg::SRC_TAB;
            end else begin
               cmd.latch_dir = 1'b1;
               cmd.rem_src   = dpff_pkg::SRC_WALK;
            end
         end
         dpff_pkg::ST_TAB_MOD: begin
            cmd.rem_src = dpff_pkg::SRC_TAB;
            cmd.rem_cap = status.rem_done;
         end
         dpff_pkg::ST_FILL: begin
            cmd.fill_write = 1'b1;
            cmd.cnt_inc    = 1'b1;
         end
         dpff_pkg::ST_WALK_MOD: begin
            cmd.rem_src = dpff_pkg::SRC_WALK;
            cmd.rem_cap = status.rem_done;
         end
         dpff_pkg::ST_PAGE_RD: begin
            cmd.rd_page = 1'b1;
         end
         dpff_pkg::ST_PAGE_CHK: begin
            cmd.page_write = !status.present;
            cmd.latch_page = status.present;
         end
         dpff_pkg::ST_DONE: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpff_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for demand_paging_fault_fill: directed and random page faults.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_FRAMES    = 16;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int IDLE_PCT      = 13;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 108;
   localparam int DRAIN_AT      = 50;
   localparam int SETTLE_CYCLES = 80;
   localparam int LIMIT_CYCLES  = 3_000_000;
   localparam int DIR_POOL      = 4;
   localparam int TAB_POOL      = 8;

   typedef struct packed {
      logic [dpff_pkg::ADDR_W-1:0]   fault_address;
      logic [dpff_pkg::TFRAME_W-1:0] table_frame;
      logic [dpff_pkg::PFRAME_W-1:0] page_frame;
   } fault_word_type;

   typedef struct packed {
      logic                         table_created;
      logic                         page_mapped;
      logic [dpff_pkg::ENTRY_W-1:0] directory_entry;
      logic [dpff_pkg::ENTRY_W-1:0] page_entry;
   } fill_word_type;

   typedef struct packed {
      fault_word_type fault;
      logic           has_want;
      fill_word_type  want;
   } directed_row_type;

   // Rows with has_want set carry a hand-computed result; the rest use the predictor.
   localparam directed_row_type DIRECTED [14] = '{
      '{'{32'h0000_0000, 4'd1,  20'hFFFFF}, 1'b1, '{1'b1, 1'b1, 32'h0000_1003, 32'hFFFF_F007}},
      '{'{32'h0000_0FFF, 4'd2,  20'h00001}, 1'b1, '{1'b0, 1'b0, 32'h0000_1003, 32'hFFFF_F007}},
      '{'{32'hFFFF_FFFF, 4'd15, 20'h00000}, 1'b1, '{1'b1, 1'b1, 32'h0000_F003, 32'h0000_0007}},
      '{'{32'h0000_1000, 4'd3,  20'hABCDE}, 1'b1, '{1'b0, 1'b1, 32'h0000_1003, 32'hABCD_E007}},
      '{'{32'hFFC0_0000, 4'd0,  20'h55555}, 1'b1, '{1'b0, 1'b1, 32'h0000_F003, 32'h5555_5007}},
      '{'{32'h003F_F000, 4'd4,  20'hAAAAA}, 1'b1, '{1'b0, 1'b1, 32'h0000_1003, 32'hAAAA_A007}},
      // The new table lands on the directory itself, so the fill wipes the directory.
      '{'{32'h0140_5000, 4'd0,  20'h12345}, 1'b0, '0},
      // The directory entry now names frame 0x12345, which wraps to frame 5.
      '{'{32'h0140_9000, 4'd6,  20'h0F0F0}, 1'b0, '0},
      '{'{32'h0000_2000, 4'd1,  20'hFFFFF}, 1'b0, '0},
      // Page frame 16 wraps onto the directory, so later page writes edit it.
      '{'{32'h0200_8000, 4'd0,  20'h00010}, 1'b0, '0},
      '{'{32'h0200_C000, 4'd5,  20'h00003}, 1'b0, '0},
      '{'{32'h0300_1000, 4'd7,  20'h00ABC}, 1'b0, '0},
      '{'{32'h8000_0000, 4'd9,  20'h80000}, 1'b0, '0},
      '{'{32'h8000_0ABC, 4'd10, 20'h7FFFF}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                         csr_write_en;
   logic [dpff_pkg::CSR_W-1:0]   csr_write_data;
   bit                           no_idle;
   int                           mismatch_count;

   logic [dpff_pkg::ENTRY_W-1:0] page_store [MEM_FRAMES*dpff_pkg::ENTRIES] = '{default: '0};
   logic [dpff_pkg::CSR_W-1:0]   dir_frame_shadow;
   logic [dpff_pkg::IDX_W-1:0]   dir_pool [DIR_POOL];
   logic [dpff_pkg::IDX_W-1:0]   tab_pool [TAB_POOL];
   fill_word_type                pending_fills [$];

   dpff_req_if req_bus ();
   dpff_rsp_if rsp_bus ();

   demand_paging_fault_fill #(
      .MEM_FRAMES(MEM_FRAMES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic int word_index(input logic [dpff_pkg::ENTRY_W-1:0] frame,
                                     input logic [dpff_pkg::IDX_W-1:0] idx);
      return int'(frame % MEM_FRAMES) * dpff_pkg::ENTRIES + int'(idx);
   endfunction

   // Walks the shadow table memory exactly as the block does and returns the response word.
   function automatic fill_word_type predict_fault_fill(input fault_word_type f);
      fill_word_type                r;
      logic [dpff_pkg::IDX_W-1:0]   dir_idx;
      logic [dpff_pkg::IDX_W-1:0]   tab_idx;
      logic [dpff_pkg::ENTRY_W-1:0] walk_frame;
      int                           dir_at;
      int                           page_at;
      int                           i;
      r       = '0;
      dir_idx = f.fault_address[dpff_pkg::DIR_SHIFT +: dpff_pkg::IDX_W];
      tab_idx = f.fault_address[dpff_pkg::TABLE_SHIFT +: dpff_pkg::IDX_W];
      dir_at  = word_index(dpff_pkg::ENTRY_W'(dir_frame_shadow), dir_idx);
      if (!page_store[dir_at][0]) begin
         page_store[dir_at] = {{(dpff_pkg::ENTRY_W-dpff_pkg::TABLE_SHIFT-dpff_pkg::TFRAME_W)
                                {1'b0}}, f.table_frame, dpff_pkg::FLAGS_DIR_NEW};
         for (i = 0; i < dpff_pkg::ENTRIES; i++) begin
            page_store[word_index(dpff_pkg::ENTRY_W'(f.table_frame), dpff_pkg::IDX_W'(i))] =
               dpff_pkg::FLAGS_TABLE_FILL;
         end
         r.table_created = 1'b1;
      end
      walk_frame = page_store[dir_at] >> dpff_pkg::TABLE_SHIFT;
      page_at    = word_index(walk_frame, tab_idx);
      if (!page_store[page_at][0]) begin
         page_store[page_at] = {f.page_frame, dpff_pkg::FLAGS_PAGE_NEW};
         r.page_mapped = 1'b1;
      end
      r.directory_entry = page_store[dir_at];
      r.page_entry      = page_store[page_at];
      return r;
   endfunction

   // Most faults reuse a few directory slots so that walks mostly hit existing tables.
   function automatic fault_word_type random_fault();
      fault_word_type f;
      f.fault_address = $urandom;
      if ($urandom_range(99) < 85) begin
         f.fault_address[dpff_pkg::DIR_SHIFT +: dpff_pkg::IDX_W] =
            dir_pool[$urandom_range(DIR_POOL-1)];
         if ($urandom_range(99) < 70) begin
            f.fault_address[dpff_pkg::TABLE_SHIFT +: dpff_pkg::IDX_W] =
               tab_pool[$urandom_range(TAB_POOL-1)];
         end
      end
      f.table_frame = dpff_pkg::TFRAME_W'($urandom);
      case ($urandom_range(9))
         0: begin
            f.page_frame = '0;
         end
         1: begin
            f.page_frame = '1;
         end
         default: begin
            f.page_frame = dpff_pkg::PFRAME_W'($urandom);
         end
      endcase
      return f;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic write_dir_frame(input logic [dpff_pkg::CSR_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en     <= 1'b0;
      dir_frame_shadow = value;
   endtask

   // Presents one fault word and records its expected response once it is taken.
   task automatic send_fault(input fault_word_type f, input logic has_want,
                             input fill_word_type want);
      fill_word_type predicted;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.fault_address <= f.fault_address;
      req_bus.table_frame   <= f.table_frame;
      req_bus.page_frame    <= f.page_frame;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_fault_fill(f);
      pending_fills.push_back(has_want ? want : predicted);
   endtask

   task automatic drain_fills();
      req_bus.valid <= 1'b0;
      while (pending_fills.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : response_check
      fill_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_fills.size() == 0) begin
            report_mismatch("response word with no fault pending");
         end else begin
            want = pending_fills.pop_front();
            if (rsp_bus.table_created !== want.table_created) begin
               report_mismatch($sformatf("table_created got %0b want %0b",
                                         rsp_bus.table_created, want.table_created));
            end
            if (rsp_bus.page_mapped !== want.page_mapped) begin
               report_mismatch($sformatf("page_mapped got %0b want %0b",
                                         rsp_bus.page_mapped, want.page_mapped));
            end
            if (rsp_bus.directory_entry !== want.directory_entry) begin
               report_mismatch($sformatf("directory_entry got %h want %h",
                                         rsp_bus.directory_entry, want.directory_entry));
            end
            if (rsp_bus.page_entry !== want.page_entry) begin
               report_mismatch($sformatf("page_entry got %h want %h",
                                         rsp_bus.page_entry, want.page_entry));
            end
         end
      end
   end

   initial begin : stimulus
      fill_word_type no_want;
      int            p;
      int            n;
      no_want               = '0;
      req_bus.valid         = 1'b0;
      req_bus.fault_address = '0;
      req_bus.table_frame   = '0;
      req_bus.page_frame    = '0;
      csr_write_en          = 1'b0;
      csr_write_data        = '0;
      no_idle               = 1'b0;
      mismatch_count        = 0;
      dir_frame_shadow      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // The block still clears its memory here but takes register writes anyway.
      write_dir_frame('0);
      foreach (DIRECTED[i]) begin
         send_fault(DIRECTED[i].fault, DIRECTED[i].has_want, DIRECTED[i].want);
      end
      drain_fills();
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               write_dir_frame('1);
            end
            2: begin
               write_dir_frame('0);
            end
            default: begin
               write_dir_frame(dpff_pkg::CSR_W'($urandom_range(14, 1)));
            end
         endcase
         no_idle = (p == 3);
         foreach (dir_pool[k]) dir_pool[k] = dpff_pkg::IDX_W'($urandom);
         foreach (tab_pool[k]) tab_pool[k] = dpff_pkg::IDX_W'($urandom);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Let the block run dry once in the middle of each phase.
            if (n == DRAIN_AT) begin
               drain_fills();
            end
            send_fault(random_fault(), 1'b0, no_want);
         end
         drain_fills();
      end
      no_idle = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_fills.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", pending_fills.size()));
      end
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("Verification failed");
      $finish;
   end

endmodule
